// ----- sv/text_console_glyph_renderer_assert.svh -----
// assertion macros for the text console glyph renderer checker
// no dependencies; included by the checker file
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication
`define TCGR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcgr assertion failed");

// next-cycle implication
`define TCGR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcgr assertion failed");

`endif

// ----- sv/tcgr_pkg.sv -----
// shared types, constants and functions of the text console glyph renderer
// no dependencies; imported by every module of the block
`default_nettype none

package tcgr_pkg;

    localparam int CELL_SIZE   = 8;
    localparam int FONT_CHARS  = 128;
    localparam int CELL_PIXELS = CELL_SIZE * CELL_SIZE;
    localparam int PIX_W       = $clog2(CELL_PIXELS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] GLYPH_MASK = 8'h7f;

    typedef enum logic [2:0] {
        REG_PITCH_BYTES    = 3'd0,
        REG_PIXEL_BYTES    = 3'd1,
        REG_TEXT_COLS      = 3'd2,
        REG_TEXT_ROWS      = 3'd3,
        REG_CHANNEL_SIZES  = 3'd4,
        REG_CHANNEL_SHIFTS = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] PITCH_RESET  = 16'd4096;
    localparam logic [2:0]  PIXEL_RESET  = 3'd4;
    localparam logic [9:0]  COLS_RESET   = 10'd128;
    localparam logic [9:0]  ROWS_RESET   = 10'd96;
    localparam logic [11:0] SIZES_RESET  = 12'd2184;
    localparam logic [14:0] SHIFTS_RESET = 15'd16456;
    localparam logic [9:0]  CELLS_MAX    = 10'd512;

    typedef struct packed {
        logic [7:0]  ch;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
    } in_item_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [31:0] byte_offset;
        logic [31:0] pixel_value;
        logic        scroll_now;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] pitch_bytes;
        logic [2:0]  pixel_bytes;
        logic [9:0]  text_cols;
        logic [9:0]  text_rows;
        logic [11:0] channel_sizes;
        logic [14:0] channel_shifts;
    } cfg_t;

    typedef struct packed {
        logic        draw;
        logic        scroll;
        logic [6:0]  glyph_idx;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [27:0] line_base;
        logic [14:0] col_base;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DRAW,
        BK_SCROLL
    } bk_state_t;

    function automatic logic [9:0] clamp_cells(input logic [9:0] v);
        logic [9:0] r;
        if (v == 10'd0)
        begin
            r = 10'd1;
        end
        else if (v > CELLS_MAX)
        begin
            r = CELLS_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [31:0] pack_channel(input logic [7:0] c8,
                                                 input logic [3:0] size,
                                                 input logic [4:0] pos);
        logic [7:0] v;
        v = (size < 4'd8) ? (c8 >> (4'd8 - size)) : c8;
        return 32'(v) << pos;
    endfunction

    function automatic logic [31:0] pack_rgb(input logic [23:0] rgb,
                                             input logic [11:0] sizes,
                                             input logic [14:0] shifts);
        return pack_channel(rgb[23:16], sizes[11:8], shifts[14:10])
             | pack_channel(rgb[15:8], sizes[7:4], shifts[9:5])
             | pack_channel(rgb[7:0], sizes[3:0], shifts[4:0]);
    endfunction

    // row 0 in the low byte
    function automatic logic [63:0] rows8(
        input logic [7:0] r0, input logic [7:0] r1, input logic [7:0] r2,
        input logic [7:0] r3, input logic [7:0] r4, input logic [7:0] r5,
        input logic [7:0] r6, input logic [7:0] r7);
        return {r7, r6, r5, r4, r3, r2, r1, r0};
    endfunction

    function automatic logic [63:0] font_glyph(input logic [6:0] idx);
        logic [63:0] g;
        case (idx)
            7'd33:  g = rows8(8'h18,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h18,8'h00);
            7'd34:  g = rows8(8'h36,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00);
            7'd35:  g = rows8(8'h36,8'h36,8'h7F,8'h36,8'h7F,8'h36,8'h36,8'h00);
            7'd36:  g = rows8(8'h0C,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h0C,8'h00);
            7'd37:  g = rows8(8'h00,8'h63,8'h33,8'h18,8'h0C,8'h66,8'h63,8'h00);
            7'd38:  g = rows8(8'h1C,8'h36,8'h1C,8'h6E,8'h3B,8'h33,8'h6E,8'h00);
            7'd39:  g = rows8(8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00);
            7'd40:  g = rows8(8'h18,8'h0C,8'h06,8'h06,8'h06,8'h0C,8'h18,8'h00);
            7'd41:  g = rows8(8'h06,8'h0C,8'h18,8'h18,8'h18,8'h0C,8'h06,8'h00);
            7'd42:  g = rows8(8'h00,8'h66,8'h3C,8'hFF,8'h3C,8'h66,8'h00,8'h00);
            7'd43:  g = rows8(8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00);
            7'd44:  g = rows8(8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h06);
            7'd45:  g = rows8(8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00);
            7'd46:  g = rows8(8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h00);
            7'd47:  g = rows8(8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h01,8'h00);
            7'd48:  g = rows8(8'h3E,8'h63,8'h73,8'h7B,8'h6F,8'h67,8'h3E,8'h00);
            7'd49:  g = rows8(8'h0C,8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00);
            7'd50:  g = rows8(8'h1E,8'h33,8'h30,8'h1C,8'h06,8'h33,8'h3F,8'h00);
            7'd51:  g = rows8(8'h1E,8'h33,8'h30,8'h1C,8'h30,8'h33,8'h1E,8'h00);
            7'd52:  g = rows8(8'h38,8'h3C,8'h36,8'h33,8'h7F,8'h30,8'h78,8'h00);
            7'd53:  g = rows8(8'h3F,8'h03,8'h1F,8'h30,8'h30,8'h33,8'h1E,8'h00);
            7'd54:  g = rows8(8'h1C,8'h06,8'h03,8'h1F,8'h33,8'h33,8'h1E,8'h00);
            7'd55:  g = rows8(8'h3F,8'h33,8'h30,8'h18,8'h0C,8'h0C,8'h0C,8'h00);
            7'd56:  g = rows8(8'h1E,8'h33,8'h33,8'h1E,8'h33,8'h33,8'h1E,8'h00);
            7'd57:  g = rows8(8'h1E,8'h33,8'h33,8'h3E,8'h30,8'h18,8'h0E,8'h00);
            7'd58:  g = rows8(8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00);
            7'd59:  g = rows8(8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h06);
            7'd60:  g = rows8(8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00);
            7'd61:  g = rows8(8'h00,8'h00,8'h3F,8'h00,8'h00,8'h3F,8'h00,8'h00);
            7'd62:  g = rows8(8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00);
            7'd63:  g = rows8(8'h1E,8'h33,8'h30,8'h18,8'h0C,8'h00,8'h0C,8'h00);
            7'd64:  g = rows8(8'h3E,8'h63,8'h7B,8'h7B,8'h7B,8'h03,8'h1E,8'h00);
            7'd65:  g = rows8(8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h00);
            7'd66:  g = rows8(8'h3F,8'h66,8'h66,8'h3E,8'h66,8'h66,8'h3F,8'h00);
            7'd67:  g = rows8(8'h3C,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3C,8'h00);
            7'd68:  g = rows8(8'h1F,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1F,8'h00);
            7'd69:  g = rows8(8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h46,8'h7F,8'h00);
            7'd70:  g = rows8(8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h06,8'h0F,8'h00);
            7'd71:  g = rows8(8'h3C,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7C,8'h00);
            7'd72:  g = rows8(8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h00);
            7'd73:  g = rows8(8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
            7'd74:  g = rows8(8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E,8'h00);
            7'd75:  g = rows8(8'h67,8'h66,8'h36,8'h1E,8'h36,8'h66,8'h67,8'h00);
            7'd76:  g = rows8(8'h0F,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7F,8'h00);
            7'd77:  g = rows8(8'h63,8'h77,8'h7F,8'h7F,8'h6B,8'h63,8'h63,8'h00);
            7'd78:  g = rows8(8'h63,8'h67,8'h6F,8'h7B,8'h73,8'h63,8'h63,8'h00);
            7'd79:  g = rows8(8'h1C,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00);
            7'd80:  g = rows8(8'h3F,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h0F,8'h00);
            7'd81:  g = rows8(8'h1E,8'h33,8'h33,8'h33,8'h3B,8'h1E,8'h38,8'h00);
            7'd82:  g = rows8(8'h3F,8'h66,8'h66,8'h3E,8'h36,8'h66,8'h67,8'h00);
            7'd83:  g = rows8(8'h1E,8'h33,8'h07,8'h0E,8'h38,8'h33,8'h1E,8'h00);
            7'd84:  g = rows8(8'h3F,8'h2D,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
            7'd85:  g = rows8(8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h00);
            7'd86:  g = rows8(8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00);
            7'd87:  g = rows8(8'h63,8'h63,8'h63,8'h6B,8'h7F,8'h77,8'h63,8'h00);
            7'd88:  g = rows8(8'h63,8'h63,8'h36,8'h1C,8'h1C,8'h36,8'h63,8'h00);
            7'd89:  g = rows8(8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h1E,8'h00);
            7'd90:  g = rows8(8'h7F,8'h63,8'h31,8'h18,8'h4C,8'h66,8'h7F,8'h00);
            7'd91:  g = rows8(8'h1E,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1E,8'h00);
            7'd92:  g = rows8(8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h40,8'h00);
            7'd93:  g = rows8(8'h1E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1E,8'h00);
            7'd94:  g = rows8(8'h08,8'h1C,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00);
            7'd95:  g = rows8(8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF);
            7'd96:  g = rows8(8'h0C,8'h0C,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00);
            7'd97:  g = rows8(8'h00,8'h00,8'h1E,8'h30,8'h3E,8'h33,8'h6E,8'h00);
            7'd98:  g = rows8(8'h07,8'h06,8'h06,8'h3E,8'h66,8'h66,8'h3B,8'h00);
            7'd99:  g = rows8(8'h00,8'h00,8'h1E,8'h33,8'h03,8'h33,8'h1E,8'h00);
            7'd100: g = rows8(8'h38,8'h30,8'h30,8'h3E,8'h33,8'h33,8'h6E,8'h00);
            7'd101: g = rows8(8'h00,8'h00,8'h1E,8'h33,8'h3F,8'h03,8'h1E,8'h00);
            7'd102: g = rows8(8'h1C,8'h36,8'h06,8'h0F,8'h06,8'h06,8'h0F,8'h00);
            7'd103: g = rows8(8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h1F);
            7'd104: g = rows8(8'h07,8'h06,8'h36,8'h6E,8'h66,8'h66,8'h67,8'h00);
            7'd105: g = rows8(8'h0C,8'h00,8'h0E,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
            7'd106: g = rows8(8'h30,8'h00,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E);
            7'd107: g = rows8(8'h07,8'h06,8'h66,8'h36,8'h1E,8'h36,8'h67,8'h00);
            7'd108: g = rows8(8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
            7'd109: g = rows8(8'h00,8'h00,8'h33,8'h7F,8'h7F,8'h6B,8'h63,8'h00);
            7'd110: g = rows8(8'h00,8'h00,8'h1F,8'h33,8'h33,8'h33,8'h33,8'h00);
            7'd111: g = rows8(8'h00,8'h00,8'h1E,8'h33,8'h33,8'h33,8'h1E,8'h00);
            7'd112: g = rows8(8'h00,8'h00,8'h3B,8'h66,8'h66,8'h3E,8'h06,8'h0F);
            7'd113: g = rows8(8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h78);
            7'd114: g = rows8(8'h00,8'h00,8'h3B,8'h6E,8'h66,8'h06,8'h0F,8'h00);
            7'd115: g = rows8(8'h00,8'h00,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h00);
            7'd116: g = rows8(8'h08,8'h0C,8'h3E,8'h0C,8'h0C,8'h2C,8'h18,8'h00);
            7'd117: g = rows8(8'h00,8'h00,8'h33,8'h33,8'h33,8'h33,8'h6E,8'h00);
            7'd118: g = rows8(8'h00,8'h00,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00);
            7'd119: g = rows8(8'h00,8'h00,8'h63,8'h6B,8'h7F,8'h7F,8'h36,8'h00);
            7'd120: g = rows8(8'h00,8'h00,8'h63,8'h36,8'h1C,8'h36,8'h63,8'h00);
            7'd121: g = rows8(8'h00,8'h00,8'h33,8'h33,8'h33,8'h3E,8'h30,8'h1F);
            7'd122: g = rows8(8'h00,8'h00,8'h3F,8'h19,8'h0C,8'h26,8'h3F,8'h00);
            7'd123: g = rows8(8'h38,8'h0C,8'h0C,8'h07,8'h0C,8'h0C,8'h38,8'h00);
            7'd124: g = rows8(8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00);
            7'd125: g = rows8(8'h07,8'h0C,8'h0C,8'h38,8'h0C,8'h0C,8'h07,8'h00);
            7'd126: g = rows8(8'h6E,8'h3B,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00);
            default: g = 64'd0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tcgr_front.sv -----
// front end: accepts characters, keeps the text cursor, builds draw and scroll commands
// depends on tcgr_pkg
`default_nettype none

module tcgr_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcgr_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tcgr_pkg::in_item_t  in_item,
    input  wire tcgr_pkg::q_status_t q_status,
    output logic                     push,
    output tcgr_pkg::cmd_t           cmd
);
    import tcgr_pkg::*;

    logic [8:0] col_reg, col_next;
    logic [8:0] line_reg, line_next;
    logic [9:0] cols_eff, rows_eff, col_inc, line_new;
    logic       accept, newline, wrap, scroll;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign newline  = (in_item.ch == CH_NEWLINE);
    assign cols_eff = clamp_cells(cfg.text_cols);
    assign rows_eff = clamp_cells(cfg.text_rows);
    assign col_inc  = {1'b0, col_reg} + 10'd1;
    assign wrap     = newline || (col_inc >= cols_eff);

    always_comb
    begin
        col_next  = wrap ? 9'd0 : col_inc[8:0];
        line_new  = {1'b0, line_reg} + {9'd0, wrap};
        scroll    = (line_new >= rows_eff);
        line_next = scroll ? 9'(rows_eff - 10'd1) : line_new[8:0];
    end

    always_comb
    begin
        cmd.draw      = !newline;
        cmd.scroll    = scroll;
        cmd.glyph_idx = 7'(in_item.ch & GLYPH_MASK);
        cmd.fg        = pack_rgb(in_item.fg_color, cfg.channel_sizes, cfg.channel_shifts);
        cmd.bg        = pack_rgb(in_item.bg_color, cfg.channel_sizes, cfg.channel_shifts);
        cmd.line_base = {line_reg, 3'b000} * cfg.pitch_bytes;
        cmd.col_base  = 15'({col_reg, 3'b000} * cfg.pixel_bytes);
        push          = accept && (!newline || scroll);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tcgr_queue.sv -----
// short command queue between the front end and the pixel generator
// depends on tcgr_pkg
`default_nettype none

module tcgr_queue #(
    parameter int DEPTH = tcgr_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tcgr_pkg::cmd_t  wr_cmd,
    input  wire logic            pop,
    output tcgr_pkg::cmd_t       rd_cmd,
    output tcgr_pkg::q_status_t  status
);
    import tcgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tcgr_back.sv -----
// back end: expands a command into 64 pixel writes or one scroll request
// depends on tcgr_pkg
`default_nettype none

module tcgr_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcgr_pkg::cfg_t      cfg,
    input  wire tcgr_pkg::q_status_t q_status,
    input  wire tcgr_pkg::cmd_t      cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tcgr_pkg::out_item_t      out_item
);
    import tcgr_pkg::*;

    bk_state_t        state_reg, state_next;
    logic [PIX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;
    logic [63:0]      glyph_reg, glyph_next;
    logic [31:0]      fg_reg, fg_next, bg_reg, bg_next;
    logic [31:0]      row_off_reg, row_off_next;
    logic [14:0]      col_off_reg, col_off_next;
    logic [14:0]      col_base_reg, col_base_next;
    logic             scroll_reg, scroll_next;
    logic             out_adv, last_pix;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_adv   = !out_valid_reg || !out_stall;
    assign last_pix  = (idx_reg == PIX_W'(CELL_PIXELS - 1));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_adv ? 1'b0 : out_valid_reg;
        out_item_next  = out_item_reg;
        glyph_next     = glyph_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        row_off_next   = row_off_reg;
        col_off_next   = col_off_reg;
        col_base_next  = col_base_reg;
        scroll_next    = scroll_reg;
        pop            = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop           = 1'b1;
                    glyph_next    = font_glyph(cmd.glyph_idx);
                    fg_next       = cmd.fg;
                    bg_next       = cmd.bg;
                    row_off_next  = 32'(cmd.line_base);
                    col_off_next  = cmd.col_base;
                    col_base_next = cmd.col_base;
                    scroll_next   = cmd.scroll;
                    idx_next      = '0;
                    state_next    = cmd.draw ? BK_DRAW : BK_SCROLL;
                end
            end
            BK_DRAW:
            begin
                if (out_adv)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.pixel_valid = 1'b1;
                    out_item_next.byte_offset = row_off_reg + 32'(col_off_reg);
                    out_item_next.pixel_value = glyph_reg[idx_reg] ? fg_reg : bg_reg;
                    out_item_next.scroll_now  = last_pix && scroll_reg;
                    out_item_next.last        = last_pix;
                    idx_next                  = idx_reg + 1'b1;
                    // end of a glyph row: back to the cell's left edge
                    if (idx_reg[2:0] == 3'd7)
                    begin
                        col_off_next = col_base_reg;
                        row_off_next = row_off_reg + 32'(cfg.pitch_bytes);
                    end
                    else
                    begin
                        col_off_next = col_off_reg + 15'(cfg.pixel_bytes);
                    end
                    if (last_pix)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_SCROLL:
            begin
                if (out_adv)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.pixel_valid = 1'b0;
                    out_item_next.byte_offset = '0;
                    out_item_next.pixel_value = '0;
                    out_item_next.scroll_now  = 1'b1;
                    out_item_next.last        = 1'b1;
                    state_next                = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        glyph_reg    <= glyph_next;
        fg_reg       <= fg_next;
        bg_reg       <= bg_next;
        row_off_reg  <= row_off_next;
        col_off_reg  <= col_off_next;
        col_base_reg <= col_base_next;
        scroll_reg   <= scroll_next;
    end

endmodule

`default_nettype wire

// ----- sv/text_console_glyph_renderer.sv -----
// top level of the text console glyph renderer: register file, front end, queue, back end
// depends on tcgr_pkg, tcgr_front, tcgr_queue, tcgr_back
//
// usage
// - input channel (in_valid, in_stall, in_item) takes one character with a foreground
//   and a background colour per transaction
// - output channel (out_valid, out_stall, out_item) gives pixel writes and scroll requests
// - any byte but a newline yields 64 pixel writes, row by row, one per cycle while the output
//   is not stalled; the last one carries last and, when the cursor ran past the bottom row, scroll_now
// - a newline yields nothing, or one scroll request when the cursor leaves the screen
// - a character passes through the queue entry, the back end's command registers and its output register
// - the pixel sequencer issues one write per cycle while the output is not stalled and goes back
//   to idle to load the next command from the queue between characters
// - the front end keeps taking characters until the command queue is full
// - a stalled output holds its transaction and freezes the pixel sequencer
// - reset puts the cursor at row 0, column 0, empties the queue and loads the
//   default mode: pitch 4096, 4 bytes per pixel, 128 x 96 cells, 8:8:8 colour
// - the user must write registers over the apb port only while the block is idle; the block itself does not enforce it
`default_nettype none

module text_console_glyph_renderer #(
    parameter int QUEUE_DEPTH = tcgr_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tcgr_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tcgr_pkg::out_item_t      out_item
);
    import tcgr_pkg::*;

    cfg_t      cfg_reg;
    cmd_t      front_cmd, queue_cmd;
    q_status_t q_status;
    logic      push, pop, wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_bytes    <= PITCH_RESET;
            cfg_reg.pixel_bytes    <= PIXEL_RESET;
            cfg_reg.text_cols      <= COLS_RESET;
            cfg_reg.text_rows      <= ROWS_RESET;
            cfg_reg.channel_sizes  <= SIZES_RESET;
            cfg_reg.channel_shifts <= SHIFTS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_PITCH_BYTES:    cfg_reg.pitch_bytes    <= pwdata[15:0];
                REG_PIXEL_BYTES:    cfg_reg.pixel_bytes    <= pwdata[2:0];
                REG_TEXT_COLS:      cfg_reg.text_cols      <= pwdata[9:0];
                REG_TEXT_ROWS:      cfg_reg.text_rows      <= pwdata[9:0];
                REG_CHANNEL_SIZES:  cfg_reg.channel_sizes  <= pwdata[11:0];
                REG_CHANNEL_SHIFTS: cfg_reg.channel_shifts <= pwdata[14:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_PITCH_BYTES:    prdata = 32'(cfg_reg.pitch_bytes);
            REG_PIXEL_BYTES:    prdata = 32'(cfg_reg.pixel_bytes);
            REG_TEXT_COLS:      prdata = 32'(cfg_reg.text_cols);
            REG_TEXT_ROWS:      prdata = 32'(cfg_reg.text_rows);
            REG_CHANNEL_SIZES:  prdata = 32'(cfg_reg.channel_sizes);
            REG_CHANNEL_SHIFTS: prdata = 32'(cfg_reg.channel_shifts);
            default:            prdata = '0;
        endcase
    end

    tcgr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_status (q_status),
        .push     (push),
        .cmd      (front_cmd)
    );

    tcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (queue_cmd),
        .status (q_status)
    );

    tcgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .cmd       (queue_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ----- sv/tcgr_checker.sv -----
// port-level checks of the text console glyph renderer, bound to the top level
// depends on tcgr_pkg and text_console_glyph_renderer_assert.svh
`default_nettype none
`include "text_console_glyph_renderer_assert.svh"

module tcgr_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire tcgr_pkg::out_item_t out_item
);
    import tcgr_pkg::*;

    // stalled transaction holds
    `TCGR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

    // a result without a pixel is a bare scroll request closing its character
    `TCGR_ASSERT_IMPL(a_bare_scroll, clk, rst_n, out_valid && !out_item.pixel_valid, out_item.scroll_now && out_item.last && out_item.byte_offset == 32'd0 && out_item.pixel_value == 32'd0)

    // scroll only on the closing result
    `TCGR_ASSERT_IMPL(a_scroll_last, clk, rst_n, out_valid && out_item.scroll_now, out_item.last)

    // pixel writes of one glyph come back to back
    `TCGR_ASSERT_NEXT(a_glyph_burst, clk, rst_n, out_valid && !out_stall && out_item.pixel_valid && !out_item.last, out_valid && out_item.pixel_valid)

endmodule

bind text_console_glyph_renderer tcgr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
